// ===== rtl/core/mkte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkte_pkg
// Shared types and constants for the multi-tap keypad text editor.
// ----------------------------------------------------------------------------
package mkte_pkg;

  localparam int KEY_COUNT  = 9;
  localparam int LINE_CHARS = 32;
  localparam int LEN_W      = 6;
  localparam int POS_W      = 5;
  localparam int COUNT_W    = 14;
  localparam int BTN_W      = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd9999;
  localparam logic [LEN_W-1:0]   LINE_FULL = LEN_W'(LINE_CHARS);
  localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(LINE_CHARS - 1);

  localparam logic [KEY_COUNT-1:0] COMBO_EXIT  = 9'h006;
  localparam logic [KEY_COUNT-1:0] COMBO_CLEAR = 9'h018;
  localparam logic [KEY_COUNT-1:0] COMBO_MODE  = 9'h030;
  localparam logic [KEY_COUNT-1:0] COMBO_TERM  = 9'h180;

  typedef enum logic [2:0] {
    EV_TYPED     = 3'd0,
    EV_CLEARED   = 3'd1,
    EV_TOGGLED   = 3'd2,
    EV_EXIT      = 3'd3,
    EV_TERMINATE = 3'd4,
    EV_IGNORED   = 3'd5
  } evt_t;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic               alpha;
    logic [COUNT_W-1:0] count;
    logic [BTN_W-1:0]   prev_button;
    logic [1:0]         tap;
  } editor_state_t;

  typedef struct packed {
    evt_t             event_res;
    logic             char_written;
    logic [POS_W-1:0] char_position;
    logic [7:0]       char_code;
    logic             shifted_left;
  } editor_result_t;

  localparam editor_state_t ST_RESET = '{
    length:      '0,
    alpha:       1'b1,
    count:       '0,
    prev_button: '0,
    tap:         '0
  };

  // letter for zero-based button index and tap index
  function automatic logic [7:0] letter_code(input logic [BTN_W-1:0] key,
                                             input logic [1:0] tap);
    logic [23:0] set;
    begin
      case (key)
        4'd0:    set = {"Z", "Q", "."};
        4'd1:    set = {"C", "B", "A"};
        4'd2:    set = {"F", "E", "D"};
        4'd3:    set = {"I", "H", "G"};
        4'd4:    set = {"L", "K", "J"};
        4'd5:    set = {"O", "N", "M"};
        4'd6:    set = {"S", "R", "P"};
        4'd7:    set = {"V", "U", "T"};
        default: set = {"Y", "X", "W"};
      endcase
      case (tap)
        2'd1:    letter_code = set[15:8];
        2'd2:    letter_code = set[23:16];
        default: letter_code = set[7:0];
      endcase
    end
  endfunction

endpackage

// ===== rtl/core/multitap_keypad_text_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitap_keypad_text_editor
// Multi-tap keypad text entry: one released button mask per transaction in,
// one editor result per transaction out.
// ----------------------------------------------------------------------------
// The block takes one button mask per cycle while in_stall is low and returns
// one result per mask: the mask is registered, and the whole editor update
// (combination decode, lowest-button select, multi-tap letter lookup, line
// length and press counter update) runs in one combinational step from that
// register into the result register and the editor state. A stall on the
// output holds both stages; the input side stalls only when both stages are
// full. Reset returns the editor to an empty line in alphabet mode with a
// zero count.
module multitap_keypad_text_editor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mkte_pkg::KEY_COUNT-1:0]   buttons,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       event_res,
  output logic                             alpha_mode,
  output logic [mkte_pkg::COUNT_W-1:0]     press_count,
  output logic [mkte_pkg::LEN_W-1:0]       text_length,
  output logic                             char_written,
  output logic [mkte_pkg::POS_W-1:0]       char_position,
  output logic [7:0]                       char_code,
  output logic                             shifted_left
);
  import mkte_pkg::*;

  logic                 stage_valid;
  logic [KEY_COUNT-1:0] stage_buttons;
  logic                 advance;
  logic                 stage_load;
  editor_state_t        state;
  editor_state_t        state_next;
  editor_result_t       result;

  assign advance    = ~out_valid | ~out_stall;
  assign stage_load = advance | ~stage_valid;
  assign in_stall   = stage_valid & ~advance;

  mkte_update u_update (
    .buttons    (stage_buttons),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage_buttons <= buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
    end else if (advance && stage_valid) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      event_res     <= result.event_res;
      alpha_mode    <= state_next.alpha;
      press_count   <= state_next.count;
      text_length   <= state_next.length;
      char_written  <= result.char_written;
      char_position <= result.char_position;
      char_code     <= result.char_code;
      shifted_left  <= result.shifted_left;
    end
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> text_length <= LINE_FULL)
    else $error("text length beyond line size");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_count <= COUNT_MAX)
    else $error("press count beyond limit");

  a_write_typed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_written) |-> event_res == EV_TYPED)
    else $error("character stored by a non-typing transaction");

  a_shift_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && shifted_left) |-> (text_length == LINE_FULL && char_position == LAST_POS))
    else $error("shift without a full line");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== rtl/core/mkte_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkte_update
// Next editor state and result for one button mask.
// ----------------------------------------------------------------------------
module mkte_update (
  input  logic [mkte_pkg::KEY_COUNT-1:0] buttons,
  input  mkte_pkg::editor_state_t        state,
  output mkte_pkg::editor_state_t        state_next,
  output mkte_pkg::editor_result_t       result
);
  import mkte_pkg::*;

  logic [BTN_W-1:0]   key;
  logic [BTN_W-1:0]   key_num;
  logic               repeat_hit;
  logic [1:0]         tap_step;
  logic               full;
  logic [COUNT_W:0]   count_sum;
  logic [1:0]         count_inc;
  logic [COUNT_W-1:0] count_next;

  // lowest pressed button
  always_comb begin
    key = BTN_W'(KEY_COUNT - 1);
    for (int i = KEY_COUNT - 2; i >= 0; i--) begin
      if (buttons[i]) begin
        key = BTN_W'(i);
      end
    end
  end

  assign key_num    = key + BTN_W'(1);
  assign repeat_hit = (state.prev_button == key_num) && (state.length != '0);
  assign tap_step   = (state.tap == 2'd0) ? 2'd1 : (state.tap == 2'd1) ? 2'd2 : 2'd0;
  assign full       = (state.length >= LINE_FULL);

  assign count_sum  = {1'b0, state.count} + {{(COUNT_W-1){1'b0}}, count_inc};
  assign count_next = (count_sum > {1'b0, COUNT_MAX}) ? '0 : count_sum[COUNT_W-1:0];

  always_comb begin
    state_next           = state;
    count_inc            = 2'd0;
    result.event_res     = EV_IGNORED;
    result.char_written  = 1'b0;
    result.char_position = '0;
    result.char_code     = '0;
    result.shifted_left  = 1'b0;
    if (buttons == '0) begin
      result.event_res = EV_IGNORED;
    end else if ((buttons & COMBO_EXIT) == COMBO_EXIT) begin
      state_next       = ST_RESET;
      result.event_res = EV_EXIT;
    end else if ((buttons & COMBO_CLEAR) == COMBO_CLEAR) begin
      state_next       = ST_RESET;
      result.event_res = EV_CLEARED;
    end else if ((buttons & COMBO_MODE) == COMBO_MODE) begin
      count_inc              = 2'd2;
      state_next.alpha       = ~state.alpha;
      state_next.prev_button = '0;
      state_next.tap         = '0;
      state_next.count       = count_next;
      result.event_res       = EV_TOGGLED;
    end else if ((buttons & COMBO_TERM) == COMBO_TERM) begin
      result.event_res = EV_TERMINATE;
    end else begin
      count_inc           = 2'd1;
      state_next.count    = count_next;
      result.event_res    = EV_TYPED;
      result.char_written = 1'b1;
      if (state.alpha && repeat_hit) begin
        state_next.tap       = tap_step;
        result.char_position = POS_W'(state.length - LEN_W'(1));
        result.char_code     = letter_code(key, tap_step);
      end else begin
        if (full) begin
          state_next.length    = LINE_FULL;
          result.char_position = LAST_POS;
          result.shifted_left  = 1'b1;
        end else begin
          state_next.length    = state.length + LEN_W'(1);
          result.char_position = state.length[POS_W-1:0];
        end
        if (state.alpha) begin
          result.char_code       = letter_code(key, 2'd0);
          state_next.prev_button = key_num;
          state_next.tap         = '0;
        end else begin
          result.char_code = 8'h31 + {4'd0, key};
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-tap keypad text editor. A driver feeds
// button masks from a backlog queue, a behavioral copy of the editor predicts
// each result at acceptance, and a monitor compares every result field by
// field. Runs through the priority of the button combinations, multi-tap
// letter cycling, numeric entry and line overflow with left shift, under
// several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mkte_pkg::*;

  typedef struct {
    logic [KEY_COUNT-1:0] mask;
    logic                 after_drain;
  } key_txn_t;

  typedef struct {
    evt_t               ev;
    logic               alpha;
    logic [COUNT_W-1:0] count;
    logic [LEN_W-1:0]   length;
    logic               written;
    logic [POS_W-1:0]   pos;
    logic [7:0]         code;
    logic               shift;
  } editor_outcome_t;

  localparam logic [KEY_COUNT-1:0] OPENING_MASKS [0:21] = '{
    9'h000, 9'h001, 9'h001, 9'h001, 9'h001, 9'h100, 9'h1FF, 9'h002,
    9'h01A, 9'h030, 9'h001, 9'h100, 9'h1C0, 9'h180, 9'h038, 9'h070,
    9'h0F0, 9'h080, 9'h006, 9'h140, 9'h040, 9'h018
  };

  localparam logic [7:0] KEYPAD_LETTERS [0:8][0:2] = '{
    '{".", "Q", "Z"}, '{"A", "B", "C"}, '{"D", "E", "F"},
    '{"G", "H", "I"}, '{"J", "K", "L"}, '{"M", "N", "O"},
    '{"P", "R", "S"}, '{"T", "U", "V"}, '{"W", "X", "Y"}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [KEY_COUNT-1:0]   buttons = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             event_res;
  logic                   alpha_mode;
  logic [COUNT_W-1:0]     press_count;
  logic [LEN_W-1:0]       text_length;
  logic                   char_written;
  logic [POS_W-1:0]       char_position;
  logic [7:0]             char_code;
  logic                   shifted_left;

  key_txn_t        mask_backlog[$];
  editor_outcome_t pending_outcomes[$];
  int              mismatch_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;

  logic [7:0]         ed_line [0:LINE_CHARS-1];
  logic [LEN_W-1:0]   ed_length;
  logic               ed_alpha;
  logic [COUNT_W-1:0] ed_count;
  logic [BTN_W-1:0]   ed_prev;
  logic [1:0]         ed_tap;

  multitap_keypad_text_editor uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .buttons       (buttons),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .alpha_mode    (alpha_mode),
    .press_count   (press_count),
    .text_length   (text_length),
    .char_written  (char_written),
    .char_position (char_position),
    .char_code     (char_code),
    .shifted_left  (shifted_left)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_editor();
    for (int i = 0; i < LINE_CHARS; i++) ed_line[i] = " ";
    ed_length = '0;
    ed_alpha  = 1'b1;
    ed_count  = '0;
    ed_prev   = '0;
    ed_tap    = '0;
  endfunction

  function automatic void bump_count(input int n);
    if (int'(ed_count) + n > int'(COUNT_MAX)) ed_count = '0;
    else ed_count = COUNT_W'(int'(ed_count) + n);
  endfunction

  function automatic void append_char(input logic [7:0] c, inout editor_outcome_t o);
    if (ed_length >= LINE_FULL) begin
      for (int i = 0; i < LINE_CHARS - 1; i++) ed_line[i] = ed_line[i + 1];
      ed_length = LINE_FULL;
      o.pos = LAST_POS;
      o.shift = 1'b1;
    end else begin
      o.pos = POS_W'(ed_length);
      ed_length = ed_length + 1'b1;
    end
    ed_line[o.pos] = c;
    o.code = c;
  endfunction

  function automatic editor_outcome_t apply_buttons(input logic [KEY_COUNT-1:0] mask);
    editor_outcome_t o;
    int k;
    o = '{EV_IGNORED, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0};
    if (mask == '0) begin
      o.ev = EV_IGNORED;
    end else if ((mask & COMBO_EXIT) == COMBO_EXIT) begin
      clear_editor();
      o.ev = EV_EXIT;
    end else if ((mask & COMBO_CLEAR) == COMBO_CLEAR) begin
      clear_editor();
      o.ev = EV_CLEARED;
    end else if ((mask & COMBO_MODE) == COMBO_MODE) begin
      ed_alpha = ~ed_alpha;
      ed_prev  = '0;
      ed_tap   = '0;
      bump_count(2);
      o.ev = EV_TOGGLED;
    end else if ((mask & COMBO_TERM) == COMBO_TERM) begin
      o.ev = EV_TERMINATE;
    end else begin
      k = 0;
      while (k < KEY_COUNT - 1 && !mask[k]) k++;
      o.written = 1'b1;
      if (ed_alpha) begin
        if (int'(ed_prev) == k + 1 && ed_length > 0) begin
          ed_tap = (ed_tap == 2'd0) ? 2'd1 : (ed_tap == 2'd1) ? 2'd2 : 2'd0;
          o.pos  = POS_W'(ed_length - 1'b1);
          o.code = KEYPAD_LETTERS[k][ed_tap];
          ed_line[o.pos] = o.code;
        end else begin
          append_char(KEYPAD_LETTERS[k][0], o);
          ed_prev = BTN_W'(k + 1);
          ed_tap  = '0;
        end
      end else begin
        append_char("1" + 8'(k), o);
      end
      bump_count(1);
      o.ev = EV_TYPED;
    end
    o.alpha  = ed_alpha;
    o.count  = ed_count;
    o.length = ed_length;
    return o;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    key_txn_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_outcomes.push_back(apply_buttons(buttons));
      if (!in_valid || !in_stall) begin
        if (mask_backlog.size() != 0 &&
            !(mask_backlog[0].after_drain && pending_outcomes.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = mask_backlog.pop_front();
          in_valid <= 1'b1;
          buttons  <= nxt.mask;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    editor_outcome_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected transaction", int'(event_res), -1);
        end else begin
          w = pending_outcomes.pop_front();
          if (event_res !== w.ev) report_mismatch("event_res", event_res, w.ev);
          if (alpha_mode !== w.alpha) report_mismatch("alpha_mode", alpha_mode, w.alpha);
          if (press_count !== w.count) report_mismatch("press_count", press_count, w.count);
          if (text_length !== w.length)
            report_mismatch("text_length", text_length, w.length);
          if (char_written !== w.written)
            report_mismatch("char_written", char_written, w.written);
          if (char_position !== w.pos)
            report_mismatch("char_position", char_position, w.pos);
          if (char_code !== w.code) report_mismatch("char_code", char_code, w.code);
          if (shifted_left !== w.shift)
            report_mismatch("shifted_left", shifted_left, w.shift);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic queue_mask(input logic [KEY_COUNT-1:0] mask, input logic drain = 1'b0);
    key_txn_t t;
    t.mask = mask;
    t.after_drain = drain;
    mask_backlog.push_back(t);
  endtask

  // lowest pressed button k with random higher buttons that form no combination
  function automatic logic [KEY_COUNT-1:0] typed_mask(input int k);
    logic [KEY_COUNT-1:0] m;
    m = KEY_COUNT'(1 << k);
    if ($urandom_range(0, 1))
      m = m | (KEY_COUNT'($urandom) & ~KEY_COUNT'((2 << k) - 1));
    if ((m & COMBO_EXIT) == COMBO_EXIT || (m & COMBO_CLEAR) == COMBO_CLEAR ||
        (m & COMBO_MODE) == COMBO_MODE || (m & COMBO_TERM) == COMBO_TERM)
      m = KEY_COUNT'(1 << k);
    return m;
  endfunction

  function automatic logic [KEY_COUNT-1:0] toggle_mask();
    return COMBO_MODE | (KEY_COUNT'($urandom) & 9'h1C3);
  endfunction

  task automatic wait_idle();
    while (mask_backlog.size() != 0 || pending_outcomes.size() != 0 || in_valid)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // clear, then a long well-formed run of typing and toggles, with some noise
  task automatic queue_sessions(input int total);
    int made;
    int len;
    int r;
    int k;
    int last_k;
    made = 0;
    last_k = 0;
    while (made < total) begin
      queue_mask(COMBO_CLEAR);
      made++;
      len = $urandom_range(40, 80);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          k = (r < 28) ? last_k : $urandom_range(0, KEY_COUNT - 1);
          queue_mask(typed_mask(k), (i == len / 2) && ($urandom_range(0, 3) == 0));
          last_k = k;
        end else if (r < 88) begin
          queue_mask(toggle_mask());
        end else if (r < 92) begin
          queue_mask(COMBO_TERM | (KEY_COUNT'($urandom) & 9'h04B));
        end else if (r < 96) begin
          queue_mask(KEY_COUNT'($urandom_range(0, 511)));
        end else begin
          queue_mask('0);
          made--;
        end
        made++;
      end
    end
  endtask

  initial begin
    clear_editor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_pace(0, 0);
    foreach (OPENING_MASKS[i]) queue_mask(OPENING_MASKS[i]);
    queue_mask(COMBO_EXIT, 1'b1);
    wait_idle();

    set_pace(55, 0);
    queue_sessions(150);
    wait_idle();

    set_pace(0, 55);
    queue_sessions(150);
    wait_idle();

    set_pace(15, 15);
    queue_sessions(150);
    wait_idle();

    set_pace(0, 0);
    queue_sessions(150);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
